FILE: rtl/flo_pkg.sv
package flo_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_ACCESS = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] item_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [31:0]        out_count;
        logic [1:0]         status;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [31:0]        count;
        logic [31:0]        first;
        logic               accessed;
    } entry_t;

    // shared by every cell of the row
    typedef struct packed {
        entry_t             load_entry;
        logic signed [31:0] key;
        logic [31:0]        rank_count;
        logic [31:0]        rank_first;
    } bcast_t;

    typedef struct packed {
        logic match;
        logic yields;
    } cell_flags_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_LEFT,
        OP_RIGHT,
        OP_HEAD
    } cell_op_t;

endpackage

FILE: rtl/flo_cell.sv
module flo_cell import flo_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cell_op_t    op,
    input  bcast_t      bcast,
    input  entry_t      left_entry,
    input  entry_t      right_entry,
    input  entry_t      head_entry,
    output entry_t      entry,
    output cell_flags_t flags
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        case (op)
            OP_LOAD:  entry_next = bcast.load_entry;
            OP_LEFT:  entry_next = left_entry;
            OP_RIGHT: entry_next = right_entry;
            OP_HEAD:  entry_next = head_entry;
            default:  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.accessed <= 1'b0;
        end else begin
            entry_reg.accessed <= entry_next.accessed;
        end
        entry_reg.value <= entry_next.value;
        entry_reg.count <= entry_next.count;
        entry_reg.first <= entry_next.first;
    end

    // key match, and whether the entry goes behind the moving one
    always_comb begin
        flags.match  = (entry_reg.value == bcast.key);
        flags.yields = (entry_reg.count < bcast.rank_count)
                    || ((entry_reg.count == bcast.rank_count)
                        && (!entry_reg.accessed || (entry_reg.first > bcast.rank_first)));
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/frequency_ordered_list_core.sv
// append (also to a full list) and access or read out of an empty list go from idle straight to the response state
// access passes through find, select, rank and move; an absent value goes from find to the response state
// throughput: one request at a time; read out gives one result per cycle as the row rotates, while m_ready is not low
// all entries are compared in parallel by the cells
// reset: synchronous, active low; clears list length, access number and accessed flags
// reset: no clearing pass, stored values are undefined until appended
module frequency_ordered_list_core import flo_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_payload,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_payload
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_SEL,
        S_RANK,
        S_MOVE,
        S_RESP,
        S_DUMP
    } state_t;

    function automatic logic [CAPACITY-1:0] lowest_one(input logic [CAPACITY-1:0] vec);
        return vec & (~vec + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] lowest_index(input logic [CAPACITY-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (vec[k]) begin
                idx = IDX_W'(k);
            end
        end
        return idx;
    endfunction

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        used_reg, used_next;
    logic [31:0]             access_num_reg, access_num_next;
    logic [31:0]             seq_reg, seq_next;
    logic signed [31:0]      item_reg, item_next;
    logic [1:0]              status_reg, status_next;
    logic [CAPACITY-1:0]     hit_reg, hit_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [31:0]             cnt_new_reg, cnt_new_next;
    logic [31:0]             first_new_reg, first_new_next;
    logic [CNT_W-1:0]        dump_reg, dump_next;
    logic                    m_valid_reg, m_valid_next;
    rsp_t                    m_payload_reg, m_payload_next;

    entry_t                  cell_entry [CAPACITY];
    cell_flags_t             cell_flags [CAPACITY];
    cell_op_t                cell_op    [CAPACITY];
    bcast_t                  bcast;
    logic [CAPACITY-1:0]     match_vec;
    logic [CAPACITY-1:0]     yield_vec;
    entry_t                  sel_entry;
    logic [IDX_W-1:0]        yield_idx;
    logic                    out_free;
    logic                    append_go;
    logic                    dump_last;

    assign out_free  = !m_valid_reg || m_ready;
    assign append_go = (state_reg == S_IDLE) && s_valid
                    && (s_payload.cmd == CMD_APPEND) && (used_reg < CNT_W'(CAPACITY));
    assign dump_last = (CNT_W'(dump_reg + 1'b1) == used_reg);
    assign yield_idx = lowest_index(yield_vec);

    always_comb begin
        if (state_reg == S_IDLE) begin
            bcast.load_entry = '{value: s_payload.item_value, count: '0, first: '0,
                                 accessed: 1'b0};
        end else begin
            bcast.load_entry = '{value: item_reg, count: cnt_new_reg, first: first_new_reg,
                                 accessed: 1'b1};
        end
        bcast.key        = item_reg;
        bcast.rank_count = cnt_new_reg;
        bcast.rank_first = first_new_reg;
    end

    always_comb begin
        sel_entry = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            match_vec[k] = cell_flags[k].match && (CNT_W'(k) < used_reg);
            yield_vec[k] = cell_flags[k].yields && (CNT_W'(k) < used_reg)
                        && (IDX_W'(k) != idx_reg);
            if (hit_reg[k]) begin
                sel_entry = sel_entry | cell_entry[k];
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        entry_t left_entry;
        entry_t right_entry;

        if (g == 0) begin : g_head
            assign left_entry = '0;
        end else begin : g_mid
            assign left_entry = cell_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = cell_entry[g+1];
        end

        always_comb begin
            cell_op[g] = OP_HOLD;
            if (append_go && (CNT_W'(g) == used_reg)) begin
                cell_op[g] = OP_LOAD;
            end else if (state_reg == S_MOVE) begin
                if (IDX_W'(g) == pos_reg) begin
                    cell_op[g] = OP_LOAD;
                end else if ((pos_reg < idx_reg) && (IDX_W'(g) > pos_reg)
                             && (IDX_W'(g) <= idx_reg)) begin
                    cell_op[g] = OP_LEFT;
                end else if ((pos_reg > idx_reg) && (IDX_W'(g) >= idx_reg)
                             && (IDX_W'(g) < pos_reg)) begin
                    cell_op[g] = OP_RIGHT;
                end
            end else if ((state_reg == S_DUMP) && out_free) begin
                if (CNT_W'(g + 1) == used_reg) begin
                    cell_op[g] = OP_HEAD;
                end else if (CNT_W'(g + 1) < used_reg) begin
                    cell_op[g] = OP_RIGHT;
                end
            end
        end

        flo_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (cell_op[g]),
            .bcast       (bcast),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .head_entry  (cell_entry[0]),
            .entry       (cell_entry[g]),
            .flags       (cell_flags[g])
        );
    end

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        access_num_next = access_num_reg;
        seq_next        = seq_reg;
        item_next       = item_reg;
        status_next     = status_reg;
        hit_next        = hit_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        cnt_new_next    = cnt_new_reg;
        first_new_next  = first_new_reg;
        dump_next       = dump_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_payload_next  = m_payload_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_payload.item_value;
                    unique case (s_payload.cmd)
                        CMD_APPEND: begin
                            if (used_reg >= CNT_W'(CAPACITY)) begin
                                status_next = ST_FULL;
                            end else begin
                                status_next = ST_OK;
                                used_next   = used_reg + 1'b1;
                            end
                            state_next = S_RESP;
                        end
                        CMD_ACCESS: begin
                            seq_next = access_num_reg;
                            if (access_num_reg != CNT_MAX) begin
                                access_num_next = access_num_reg + 1'b1;
                            end
                            if (used_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_FIND;
                            end
                        end
                        CMD_DUMP: begin
                            dump_next = '0;
                            if (used_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIND: begin
                hit_next = lowest_one(match_vec);
                if (match_vec == '0) begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else begin
                    state_next = S_SEL;
                end
            end
            S_SEL: begin
                idx_next     = lowest_index(hit_reg);
                cnt_new_next = (sel_entry.count == CNT_MAX) ? sel_entry.count
                                                            : sel_entry.count + 1'b1;
                first_new_next = (sel_entry.accessed && (sel_entry.first < seq_reg))
                               ? sel_entry.first : seq_reg;
                state_next = S_RANK;
            end
            S_RANK: begin
                if (yield_vec == '0) begin
                    pos_next = IDX_W'(used_reg - 1'b1);
                end else if (yield_idx < idx_reg) begin
                    pos_next = yield_idx;
                end else begin
                    pos_next = yield_idx - 1'b1;
                end
                state_next = S_MOVE;
            end
            S_MOVE: begin
                status_next = ST_OK;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = '{out_value: '0, out_count: '0, status: status_reg,
                                       last: 1'b1};
                    state_next     = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = '{out_value: cell_entry[0].value,
                                       out_count: cell_entry[0].count,
                                       status: ST_OK, last: dump_last};
                    dump_next      = dump_reg + 1'b1;
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            access_num_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            access_num_reg <= access_num_next;
            m_valid_reg    <= m_valid_next;
        end
        seq_reg       <= seq_next;
        item_reg      <= item_next;
        status_reg    <= status_next;
        hit_reg       <= hit_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        cnt_new_reg   <= cnt_new_next;
        first_new_reg <= first_new_next;
        dump_reg      <= dump_next;
        m_payload_reg <= m_payload_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_move_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE) |-> $onehot(hit_reg))
        else $error("move without a single selected entry");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        append_go |=> (used_reg == $past(used_reg) + 1'b1))
        else $error("append did not grow the list");

    a_dump_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DUMP) |-> (dump_reg < used_reg))
        else $error("read out index past the tail");

endmodule

FILE: tb/tb_frequency_ordered_list_core.sv
`timescale 1ns / 100ps

module tb_frequency_ordered_list_core;
    import flo_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int RANDOM_ITEMS = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        req_t req;
        bit   known;
        rsp_t rsp;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_payload;

    entry_t   ranking[$];
    logic [31:0] access_seq = '0;
    rsp_t     fresh[$];
    rsp_t     pending_rsp[$];
    dir_row_t directed[$];

    int  fail_cnt = 0;
    int  cycle_cnt = 0;
    int  rx_stall = 0;
    bit  tx_calm = 0;
    bit  rx_calm = 0;

    frequency_ordered_list_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always #5 aclk = ~aclk;

    function automatic bit goes_behind(entry_t h, logic [31:0] cnt, logic [31:0] first);
        if (h.count < cnt) return 1'b1;
        if (h.count == cnt) return !h.accessed || (h.first > first);
        return 1'b0;
    endfunction

    function automatic void rank_request(req_t r);
        entry_t e;
        rsp_t rs;
        logic [31:0] seq;
        int hit;
        int pos;
        fresh.delete();
        rs = '0;
        rs.last = 1'b1;
        case (r.cmd)
            CMD_APPEND: begin
                if (ranking.size() >= CAPACITY) begin
                    rs.status = ST_FULL;
                end else begin
                    e = '0;
                    e.value = r.item_value;
                    ranking.push_back(e);
                    rs.status = ST_OK;
                end
                fresh.push_back(rs);
            end
            CMD_ACCESS: begin
                seq = access_seq;
                if (access_seq != CNT_MAX) access_seq++;
                hit = -1;
                for (int i = 0; i < ranking.size(); i++) begin
                    if (ranking[i].value == r.item_value) begin
                        hit = i;
                        break;
                    end
                end
                if (ranking.size() == 0) begin
                    rs.status = ST_EMPTY;
                end else if (hit < 0) begin
                    rs.status = ST_NOT_FOUND;
                end else begin
                    e = ranking[hit];
                    ranking.delete(hit);
                    if (e.count != CNT_MAX) e.count++;
                    if (!(e.accessed && e.first < seq)) e.first = seq;
                    e.accessed = 1'b1;
                    pos = ranking.size();
                    for (int i = 0; i < ranking.size(); i++) begin
                        if (goes_behind(ranking[i], e.count, e.first)) begin
                            pos = i;
                            break;
                        end
                    end
                    ranking.insert(pos, e);
                    rs.status = ST_OK;
                end
                fresh.push_back(rs);
            end
            CMD_DUMP: begin
                if (ranking.size() == 0) begin
                    rs.status = ST_EMPTY;
                    fresh.push_back(rs);
                end else begin
                    foreach (ranking[i]) begin
                        rs.out_value = ranking[i].value;
                        rs.out_count = ranking[i].count;
                        rs.status = ST_OK;
                        rs.last = (i == ranking.size() - 1);
                        fresh.push_back(rs);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [31:0] val, bit known,
                                    logic [1:0] st);
        dir_row_t d;
        d.req.cmd = cmd;
        d.req.item_value = val;
        d.known = known;
        d.rsp = '0;
        d.rsp.status = st;
        d.rsp.last = 1'b1;
        directed.push_back(d);
    endfunction

    task automatic send(req_t r, bit known, rsp_t typed_rsp);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        rank_request(r);
        if (known) begin
            pending_rsp.push_back(typed_rsp);
        end else begin
            foreach (fresh[i]) pending_rsp.push_back(fresh[i]);
        end
    endtask

    // result side: check and random back-pressure
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result: value %0d count %0d status %0d last %0d",
                             m_payload.out_value, m_payload.out_count,
                             m_payload.status, m_payload.last);
            end else begin
                want = pending_rsp.pop_front();
                if (m_payload.out_value !== want.out_value ||
                    m_payload.out_count !== want.out_count ||
                    m_payload.status !== want.status ||
                    m_payload.last !== want.last) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display({"mismatch: value %0d/%0d count %0d/%0d",
                                  " status %0d/%0d last %0d/%0d"},
                                 want.out_value, m_payload.out_value,
                                 want.out_count, m_payload.out_count,
                                 want.status, m_payload.status,
                                 want.last, m_payload.last);
                end
            end
            rx_stall = rx_calm ? 0 : $urandom_range(0, 9);
        end
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("frequency_ordered_list_core regression: fail");
            $finish;
        end
    end

    initial begin
        req_t r;
        int n_items;
        int pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        add_row(CMD_DUMP,    32'd0,          1, ST_EMPTY);
        add_row(CMD_ACCESS,  32'd5,          1, ST_EMPTY);
        add_row(CMD_UNKNOWN, 32'd7,          0, ST_OK);
        add_row(CMD_APPEND,  32'h8000_0000,  1, ST_OK);
        add_row(CMD_APPEND,  32'h7FFF_FFFF,  1, ST_OK);
        add_row(CMD_APPEND,  32'd0,          1, ST_OK);
        add_row(CMD_APPEND,  32'hFFFF_FFFF,  1, ST_OK);
        add_row(CMD_APPEND,  32'd1234,       1, ST_OK);
        add_row(CMD_ACCESS,  32'd1919810,    1, ST_NOT_FOUND);
        add_row(CMD_DUMP,    32'd0,          0, ST_OK);
        add_row(CMD_ACCESS,  32'hFFFF_FFFF,  1, ST_OK);
        // equal count, later first access stays behind
        add_row(CMD_ACCESS,  32'd0,          1, ST_OK);
        add_row(CMD_ACCESS,  32'h7FFF_FFFF,  1, ST_OK);
        add_row(CMD_ACCESS,  32'd0,          1, ST_OK);
        add_row(CMD_DUMP,    32'hFFFF_FFFF,  0, ST_OK);
        // duplicate value, only the entry nearest the head moves
        add_row(CMD_APPEND,  32'd0,          1, ST_OK);
        add_row(CMD_ACCESS,  32'd0,          1, ST_OK);
        add_row(CMD_ACCESS,  32'd1234,       1, ST_OK);
        add_row(CMD_DUMP,    32'd0,          0, ST_OK);
        add_row(CMD_UNKNOWN, 32'hFFFF_FFFF,  0, ST_OK);
        add_row(CMD_ACCESS,  32'h8000_0000,  1, ST_OK);
        add_row(CMD_DUMP,    32'd0,          0, ST_OK);

        foreach (directed[i]) send(directed[i].req, directed[i].known, directed[i].rsp);

        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            if (n_items % 20 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (n_items == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (pending_rsp.size() != 0);
            end
            pick = $urandom_range(0, 99);
            r.item_value = $urandom;
            if (pick < 35) begin
                r.cmd = CMD_APPEND;
                if (ranking.size() != 0 && $urandom_range(0, 19) == 0)
                    r.item_value = ranking[$urandom_range(0, ranking.size() - 1)].value;
            end else if (pick < 85) begin
                r.cmd = CMD_ACCESS;
                // favor entries near the head so counts pull apart
                if (ranking.size() != 0 && $urandom_range(0, 9) < 8)
                    r.item_value = ranking[$urandom_range(0,
                        $urandom_range(0, ranking.size() - 1))].value;
            end else if (pick < 95) begin
                r.cmd = CMD_DUMP;
            end else begin
                r.cmd = CMD_UNKNOWN;
            end
            send(r, 0, '0);
            if (r.cmd != CMD_UNKNOWN) n_items++;
        end
        s_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("frequency_ordered_list_core regression: pass");
        end else begin
            $display("frequency_ordered_list_core regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/flo_pkg.sv
rtl/flo_cell.sv
rtl/frequency_ordered_list_core.sv
tb/tb_frequency_ordered_list_core.sv
